// ===== rtl/cfq_pkg.sv =====
// Package of the circular FIFO queue: sizes, operation codes, request and
// result structs, and the control bundle that drives the storage cells.
// No dependencies.
package cfq_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned IdxW      = $clog2(Depth);
  localparam int unsigned CntW      = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    ModeEnq   = 2'd0,
    ModeDeq   = 2'd1,
    ModePeek  = 2'd2,
    ModeClear = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e                mode;
    logic [DataWidth-1:0] data_in;
  } in_req_t;

  typedef struct packed {
    logic                 ok;
    logic [DataWidth-1:0] data_out;
    logic [CntW-1:0]      count;
    logic                 is_empty;
  } out_rsp_t;

  typedef struct packed {
    logic wr_en;
    logic head_adv;
    logic tail_adv;
    logic clr;
  } cell_ctrl_t;

endpackage

// ===== rtl/circular_fifo_queue.sv =====
// Top level of the circular FIFO queue: capacity register, fill count,
// result register and the row of cfq_cell storage cells. Depends on cfq_pkg.
//
//   channel | direction | handshake                 | payload
//   in      | request   | in_valid_i / in_ready_o   | in_req_i  (mode, data_in)
//   out     | result    | out_valid_o / out_ready_i | out_rsp_o (ok, data_out, count, is_empty)
//   cfg     | write     | cfg_valid_i / cfg_ready_o | cfg_data_i (capacity)
//
// One request is taken per cycle while the result register is free or being
// read; its result is registered and appears in the cycle after. Head and tail
// are one-hot tokens that step one cell per operation.
// A stalled result holds the request side only while the result register is full.
// Reset sets capacity to sixteen and puts both tokens on cell zero with the queue empty.
module circular_fifo_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  cfq_pkg::in_req_t             in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output cfq_pkg::out_rsp_t            out_rsp_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cfq_pkg::CntW-1:0]     cfg_data_i
);

  localparam int unsigned N = cfq_pkg::Depth;

  logic [cfq_pkg::CntW-1:0]      cap_q;
  logic [cfq_pkg::CntW-1:0]      cap_eff;
  logic [cfq_pkg::CntW-1:0]      fill_q, fill_d;
  logic                          out_valid_q;
  cfq_pkg::out_rsp_t             out_rsp_q, out_rsp_d;
  cfq_pkg::cell_ctrl_t           ctrl;
  logic                          accept;

  logic [N-1:0]                  head_pass, head_wrap, tail_pass, tail_wrap;
  logic [N-1:0]                  head_in, tail_in;
  logic [cfq_pkg::DataWidth-1:0] rdata [N];
  logic [cfq_pkg::DataWidth-1:0] head_word;

  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign accept      = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // saturate the capacity to one..depth
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = cfq_pkg::CntW'(1);
    end else if (cap_q > cfq_pkg::CntW'(N)) begin
      cap_eff = cfq_pkg::CntW'(N);
    end else begin
      cap_eff = cap_q;
    end
  end

  // the first cell collects every token that wraps
  always_comb begin
    head_in[0] = |head_wrap;
    tail_in[0] = |tail_wrap;
    for (int i = 1; i < N; i++) begin
      head_in[i] = head_pass[i-1];
      tail_in[i] = tail_pass[i-1];
    end
  end

  always_comb begin
    head_word = '0;
    for (int i = 0; i < N; i++) begin
      head_word = head_word | rdata[i];
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    cfq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (cfq_pkg::IdxW'(g)),
      .cap_i       (cap_eff),
      .ctrl_i      (ctrl),
      .wdata_i     (in_req_i.data_in),
      .head_in_i   (head_in[g]),
      .tail_in_i   (tail_in[g]),
      .head_pass_o (head_pass[g]),
      .head_wrap_o (head_wrap[g]),
      .tail_pass_o (tail_pass[g]),
      .tail_wrap_o (tail_wrap[g]),
      .rdata_o     (rdata[g])
    );
  end

  always_comb begin
    ctrl               = '0;
    fill_d             = fill_q;
    out_rsp_d.ok       = 1'b0;
    out_rsp_d.data_out = '0;
    case (in_req_i.mode)
      cfq_pkg::ModeEnq: begin
        if (fill_q < cap_eff) begin
          ctrl.wr_en    = accept;
          ctrl.tail_adv = accept;
          fill_d        = fill_q + cfq_pkg::CntW'(1);
          out_rsp_d.ok  = 1'b1;
        end
      end
      cfq_pkg::ModeDeq: begin
        if (fill_q != '0) begin
          ctrl.head_adv      = accept;
          fill_d             = fill_q - cfq_pkg::CntW'(1);
          out_rsp_d.ok       = 1'b1;
          out_rsp_d.data_out = head_word;
        end
      end
      cfq_pkg::ModePeek: begin
        if (fill_q != '0) begin
          out_rsp_d.ok       = 1'b1;
          out_rsp_d.data_out = head_word;
        end
      end
      cfq_pkg::ModeClear: begin
        ctrl.clr     = accept;
        fill_d       = '0;
        out_rsp_d.ok = 1'b1;
      end
      default: begin
        fill_d = fill_q;
      end
    endcase
    out_rsp_d.count    = fill_d;
    out_rsp_d.is_empty = (fill_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= cfq_pkg::CntW'(N);
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) cap_q <= cfg_data_i;
      if (accept) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_rsp_q <= out_rsp_d;
  end

endmodule

// ===== rtl/cfq_cell.sv =====
// One storage cell of the queue: a data word plus the head and tail tokens
// that travel along the row of cells. Depends on cfq_pkg.
module cfq_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [cfq_pkg::IdxW-1:0]     cell_idx_i,
  input  logic [cfq_pkg::CntW-1:0]     cap_i,
  input  cfq_pkg::cell_ctrl_t          ctrl_i,
  input  logic [cfq_pkg::DataWidth-1:0] wdata_i,
  input  logic                         head_in_i,
  input  logic                         tail_in_i,
  output logic                         head_pass_o,
  output logic                         head_wrap_o,
  output logic                         tail_pass_o,
  output logic                         tail_wrap_o,
  output logic [cfq_pkg::DataWidth-1:0] rdata_o
);

  logic                          head_q, head_d;
  logic                          tail_q, tail_d;
  logic [cfq_pkg::DataWidth-1:0] data_q;
  logic                          is_first;
  logic                          wrap;

  assign is_first = (cell_idx_i == '0);
  // the next slot lies at or past the capacity: hand the token back to cell zero
  assign wrap = ({1'b0, cell_idx_i} + cfq_pkg::CntW'(1)) >= cap_i;

  assign head_pass_o = head_q & ~wrap;
  assign head_wrap_o = head_q & wrap;
  assign tail_pass_o = tail_q & ~wrap;
  assign tail_wrap_o = tail_q & wrap;
  assign rdata_o     = head_q ? data_q : '0;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (ctrl_i.clr) begin
      head_d = is_first;
      tail_d = is_first;
    end else begin
      if (ctrl_i.head_adv) head_d = head_in_i;
      if (ctrl_i.tail_adv) tail_d = tail_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= is_first;
      tail_q <= is_first;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en && tail_q) begin
      data_q <= wdata_i;
    end
  end

endmodule

// ===== verif/tb_circular_fifo_queue.sv =====
// Self-checking bench for circular_fifo_queue: a shadow queue predicts each
// result from the accepted requests and checks the results in order.
// Depends on cfq_pkg and circular_fifo_queue.
`timescale 1ns / 1ps

module tb_circular_fifo_queue;

  localparam int unsigned IdlePct      = 28;
  localparam int unsigned PhaseLen     = 100;
  localparam int unsigned PhaseCount   = 20;
  localparam int unsigned HoldAtResult = 1300;
  localparam int unsigned HoldCycles   = 150;

  // Shadow of the queue: storage, pointers, fill level and capacity, plus the
  // results still owed by the block.
  class fifo_shadow;
    logic [cfq_pkg::DataWidth-1:0] slots [cfq_pkg::Depth];
    bit   [cfq_pkg::Depth-1:0]     written;
    logic [cfq_pkg::IdxW-1:0]      head;
    logic [cfq_pkg::IdxW-1:0]      tail;
    logic [cfq_pkg::CntW-1:0]      fill;
    logic [cfq_pkg::CntW-1:0]      capacity;
    cfq_pkg::out_rsp_t             owed_rsps [$];
    int unsigned                   errors;

    function new();
      written  = '0;
      head     = '0;
      tail     = '0;
      fill     = '0;
      capacity = cfq_pkg::CntW'(cfq_pkg::Depth);
      errors   = 0;
    endfunction

    function void set_capacity(logic [cfq_pkg::CntW-1:0] value);
      capacity = value;
    endfunction

    function int unsigned live_capacity();
      if (capacity == 0) return 1;
      if (capacity > cfq_pkg::Depth) return cfq_pkg::Depth;
      return capacity;
    endfunction

    function logic [cfq_pkg::IdxW-1:0] step_ptr(logic [cfq_pkg::IdxW-1:0] ptr,
                                                int unsigned cap);
      int unsigned nxt;
      nxt = ptr + 1;
      return (nxt >= cap) ? '0 : nxt[cfq_pkg::IdxW-1:0];
    endfunction

    // A read here would hit a slot that was never written.
    function bit head_is_blank();
      return (fill != 0) && !written[head];
    endfunction

    function int unsigned pending();
      return owed_rsps.size();
    endfunction

    function void take_request(cfq_pkg::in_req_t req);
      cfq_pkg::out_rsp_t rsp;
      int unsigned       cap;
      cap = live_capacity();
      rsp = '0;
      case (req.mode)
        cfq_pkg::ModeEnq: begin
          if (fill < cap) begin
            slots[tail]   = req.data_in;
            written[tail] = 1'b1;
            tail          = step_ptr(tail, cap);
            fill          = fill + 1'b1;
            rsp.ok        = 1'b1;
          end
        end
        cfq_pkg::ModeDeq, cfq_pkg::ModePeek: begin
          if (fill != 0) begin
            rsp.data_out = slots[head];
            if (req.mode == cfq_pkg::ModeDeq) begin
              head = step_ptr(head, cap);
              fill = fill - 1'b1;
            end
            rsp.ok = 1'b1;
          end
        end
        default: begin
          head   = '0;
          tail   = '0;
          fill   = '0;
          rsp.ok = 1'b1;
        end
      endcase
      rsp.count    = fill;
      rsp.is_empty = (fill == 0);
      owed_rsps.push_back(rsp);
    endfunction

    function void check_response(cfq_pkg::out_rsp_t got);
      cfq_pkg::out_rsp_t want;
      if (owed_rsps.size() == 0) begin
        $error("result with no request outstanding: %p", got);
        errors++;
        return;
      end
      want = owed_rsps.pop_front();
      if (got.ok !== want.ok) begin
        $error("ok: expected %0b, got %0b", want.ok, got.ok);
        errors++;
      end
      if (got.data_out !== want.data_out) begin
        $error("data_out: expected %h, got %h", want.data_out, got.data_out);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  cfq_pkg::in_req_t         in_req_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  cfq_pkg::out_rsp_t        out_rsp_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [cfq_pkg::CntW-1:0] cfg_data_i;

  fifo_shadow  sb;
  int unsigned item_idx;

  circular_fifo_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic cfq_pkg::in_req_t op(cfq_pkg::mode_e m,
                                          logic [cfq_pkg::DataWidth-1:0] d);
    cfq_pkg::in_req_t req;
    req.mode    = m;
    req.data_in = d;
    return req;
  endfunction

  // Enter and leave at a falling edge; valid is left high for the next request.
  task automatic send_request(input cfq_pkg::in_req_t req, input bit gapless);
    while (!gapless && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_request(req);
    item_idx++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [cfq_pkg::CntW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_capacity(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : result_sink
    int unsigned seen;
    bit          held;
    seen        = 0;
    held        = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_response(out_rsp_o);
        seen++;
      end
      @(negedge clk_i);
      // Hold off long enough for the request side to back up.
      if (!held && seen == HoldAtResult) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if (seen >= 600 && seen < 1000) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(99) >= IdlePct);
    end
  end

  initial begin : stimulus
    logic [cfq_pkg::CntW-1:0] cap_plan [7];
    cfq_pkg::in_req_t         req;
    int unsigned              enq_pct;
    int unsigned              pick;
    cap_plan    = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd2, 5'd15, 5'd8};
    sb          = new();
    item_idx    = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Refused reads on empty, both data extremes, read past the last word, clear.
    send_request(op(cfq_pkg::ModeDeq, 32'h0), 1'b0);
    send_request(op(cfq_pkg::ModePeek, 32'h0), 1'b0);
    send_request(op(cfq_pkg::ModeEnq, 32'h0000_0000), 1'b0);
    send_request(op(cfq_pkg::ModeEnq, 32'hFFFF_FFFF), 1'b0);
    send_request(op(cfq_pkg::ModePeek, 32'h0), 1'b0);
    send_request(op(cfq_pkg::ModeDeq, 32'h0), 1'b0);
    send_request(op(cfq_pkg::ModeDeq, 32'h0), 1'b0);
    send_request(op(cfq_pkg::ModeDeq, 32'h0), 1'b0);
    send_request(op(cfq_pkg::ModeEnq, 32'h1234_5678), 1'b0);
    send_request(op(cfq_pkg::ModeClear, 32'hFFFF_FFFF), 1'b0);
    send_request(op(cfq_pkg::ModePeek, 32'h0), 1'b0);
    wait_drained();

    // Single entry: full after one word, pointers wrap every step.
    write_capacity(5'd1);
    send_request(op(cfq_pkg::ModeEnq, 32'hA5A5_A5A5), 1'b0);
    send_request(op(cfq_pkg::ModeEnq, 32'h5A5A_5A5A), 1'b0);
    send_request(op(cfq_pkg::ModePeek, 32'h0), 1'b0);
    send_request(op(cfq_pkg::ModeDeq, 32'h0), 1'b0);
    send_request(op(cfq_pkg::ModeEnq, 32'h0000_0001), 1'b0);
    send_request(op(cfq_pkg::ModeEnq, 32'h0000_0002), 1'b0);
    send_request(op(cfq_pkg::ModeDeq, 32'h0), 1'b0);
    wait_drained();

    // Zero capacity behaves as one.
    write_capacity(5'd0);
    send_request(op(cfq_pkg::ModeEnq, 32'hDEAD_BEEF), 1'b0);
    send_request(op(cfq_pkg::ModeEnq, 32'hCAFE_F00D), 1'b0);
    send_request(op(cfq_pkg::ModeDeq, 32'h0), 1'b0);
    wait_drained();

    // Phases of random requests; capacity changes with whatever the queue holds.
    for (int p = 0; p < PhaseCount; p++) begin
      if (p < 7) write_capacity(cap_plan[p]);
      else write_capacity(cfq_pkg::CntW'($urandom_range(31)));
      enq_pct = 20 + 25 * $urandom_range(3);
      for (int i = 0; i < PhaseLen; i++) begin
        pick = $urandom_range(99);
        if (pick < 3) req.mode = cfq_pkg::ModeClear;
        else if (pick < 18) req.mode = cfq_pkg::ModePeek;
        else if ($urandom_range(99) < enq_pct) req.mode = cfq_pkg::ModeEnq;
        else req.mode = cfq_pkg::ModeDeq;
        // Drop to a clear rather than read storage that holds nothing yet.
        if ((req.mode == cfq_pkg::ModeDeq || req.mode == cfq_pkg::ModePeek) &&
            sb.head_is_blank())
          req.mode = cfq_pkg::ModeClear;
        req.data_in = $urandom;
        send_request(req, (item_idx >= 500 && item_idx < 900));
      end
      wait_drained();
    end

    repeat (5) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("circular_fifo_queue regression: pass");
    end else begin
      $display("circular_fifo_queue regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("circular_fifo_queue regression: fail");
    $finish;
  end

endmodule
